/* rtl/swm_pkg.sv */
// swm_pkg: shared constants, types and cell commands for the sliding window median.
// No dependencies; compile first.
package swm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int PTR_BITS    = $clog2(WINDOW_MAX);
   localparam int RESULT_BITS = 17;
   localparam int WSIZE_BITS  = 7;
   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(3);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_CLEAR  = 2'd3
   } cell_op_type;

   // command broadcast to every cell
   typedef struct packed {
      cell_op_type op;
      sample_type  key;
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      sample_type val;
      logic       occ;
      logic       mov;
   } cell_type;

endpackage

/* rtl/swm_if.sv */
// swm_if: valid/ready channels of the sliding window median (request, response, csr write).
// Depends on swm_pkg.
interface swm_req_if import swm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       restart;
   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [RESULT_BITS-1:0] median_doubled;
   modport source (output valid, output median_doubled, input ready);
   modport sink   (input valid, input median_doubled, output ready);
endinterface

interface swm_csr_if import swm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WSIZE_BITS-1:0] window_size;
   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

/* rtl/swm_ram.sv */
// swm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/swm_cell.sv */
// swm_cell: one slot of the sorted window; shifts toward or away from its neighbors.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  cell_type     left,
   input  cell_type     right,
   output cell_type     out
);

   sample_type val_ff, val_in;
   logic       occ_ff, occ_in;
   logic       mov;

   // insert: slot is past the insertion point; delete: slot is at or past the victim
   always_comb begin
      unique case (cmd.op)
         CELL_INSERT: mov = !occ_ff || (val_ff > cmd.key);
         CELL_DELETE: mov = occ_ff && (val_ff >= cmd.key);
         CELL_HOLD:   mov = 1'b0;
         CELL_CLEAR:  mov = 1'b0;
         default:     mov = 1'b0;
      endcase
   end

   always_comb begin
      val_in = val_ff;
      occ_in = occ_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            val_in = left.mov ? left.val : (mov ? cmd.key : val_ff);
            occ_in = left.occ;
         end
         CELL_DELETE: begin
            val_in = mov ? right.val : val_ff;
            occ_in = mov ? right.occ : occ_ff;
         end
         CELL_CLEAR: begin
            occ_in = 1'b0;
         end
         CELL_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign out = '{val: val_ff, occ: occ_ff, mov: mov};

endmodule

/* rtl/sliding_window_median.sv */
// sliding_window_median: top level, sequencer, cell row, arrival-order history RAM.
// Depends on swm_pkg, swm_if, swm_ram, swm_cell.

// Running median of the last window_size signed 16-bit samples, reported as twice the
// median (17-bit signed, one fraction bit) once the window is full. The samples sit in
// a row of WINDOW_MAX cells kept in ascending order; a new sample is inserted by every
// cell comparing against it and the cells past the insertion point shifting one place.
// The oldest sample is found in a circular history RAM and removed from the row by value
// (equal values are interchangeable for the median). A request is accepted, looks up the
// RAM and inserts; a full window removes its oldest sample before the insert, and the
// request that completes the window also loads the result. After window_size is lowered,
// the first request repeats lookup and removal for each surplus sample it drops. The
// result cycle waits as long as the previous result is not taken. A restart request
// empties the window first. The request side is ready again while a result still waits
// in the response register. window_size is written through the csr channel (always
// ready); the user must write it only while the block is idle, which the block does not
// enforce. 0 acts as 1, values above 64 act as 64. No clearing pass is needed after reset.
module sliding_window_median import swm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   swm_req_if.sink   req,
   swm_rsp_if.source rsp,
   swm_csr_if.sink   csr
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_DEL  = 5'b00100,
      ST_INS  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [WSIZE_BITS-1:0] window_size_ff, window_size_in;
   logic [COUNT_BITS-1:0] w_eff;
   logic [COUNT_BITS-1:0] fill_count_ff, fill_count_in;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   sample_type            sample_ff, sample_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  rsp_free;
   logic [PTR_BITS-1:0]   oldest_addr;
   logic [SAMPLE_BITS-1:0] oldest_raw;
   logic                  ram_wr_en;
   cell_cmd_type          cmd;
   cell_type              cells [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] occ_vec;
   logic [PTR_BITS-1:0]   lo_idx, hi_idx;
   logic signed [RESULT_BITS-1:0] median_sum;

   // ---------------- configuration ----------------
   assign csr.ready = 1'b1;
   assign window_size_in = (csr.valid && csr.ready) ? csr.window_size : window_size_ff;

   // clamp: zero acts as one, anything above the row length acts as the row length
   always_comb begin
      priority if (window_size_ff == '0) begin
         w_eff = COUNT_BITS'(1);
      end else if (COUNT_BITS'(window_size_ff) > COUNT_BITS'(WINDOW_MAX)) begin
         w_eff = COUNT_BITS'(WINDOW_MAX);
      end else begin
         w_eff = COUNT_BITS'(window_size_ff);
      end
   end

   // ---------------- handshakes ----------------
   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // oldest live sample in arrival order; full circle when the count is the row length
   assign oldest_addr = wr_ptr_ff - fill_count_ff[PTR_BITS-1:0];
   assign ram_wr_en   = (state_ff == ST_INS);

   swm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (sample_ff),
      .rd_addr (oldest_addr),
      .rd_data (oldest_raw)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      wr_ptr_in     = wr_ptr_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      cmd.op        = CELL_HOLD;
      cmd.key       = sample_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req.sample;
               state_in  = ST_READ;
               if (req.restart) begin
                  fill_count_in = '0;
                  cmd.op        = CELL_CLEAR;
               end
            end
         end
         ST_READ: begin
            // RAM address is settled this cycle; data shows up in ST_DEL
            state_in = (fill_count_ff >= w_eff) ? ST_DEL : ST_INS;
         end
         ST_DEL: begin
            cmd.op        = CELL_DELETE;
            cmd.key       = sample_type'(oldest_raw);
            fill_count_in = fill_count_ff - COUNT_BITS'(1);
            state_in      = (fill_count_in >= w_eff) ? ST_READ : ST_INS;
         end
         ST_INS: begin
            cmd.op        = CELL_INSERT;
            fill_count_in = fill_count_ff + COUNT_BITS'(1);
            wr_ptr_in     = wr_ptr_ff + PTR_BITS'(1);
            state_in      = (fill_count_in == w_eff) ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = median_sum;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= WSIZE_RESET;
         fill_count_ff  <= '0;
         wr_ptr_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         fill_count_ff  <= fill_count_in;
         wr_ptr_ff      <= wr_ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.median_doubled = rsp_data_ff;

   // ---------------- sorted cell row ----------------
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      cell_type left_nb, right_nb;
      if (i == 0) begin : g_first
         // insert at slot 0 always occupies it; nothing moves in from the left
         assign left_nb = '{val: '0, occ: 1'b1, mov: 1'b0};
      end else begin : g_mid_l
         assign left_nb = cells[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_last
         assign right_nb = '{val: '0, occ: 1'b0, mov: 1'b0};
      end else begin : g_mid_r
         assign right_nb = cells[i+1];
      end
      swm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left_nb),
         .right (right_nb),
         .out   (cells[i])
      );
      assign occ_vec[i] = cells[i].occ;
   end

   // middle slots; odd windows pick the same slot twice
   assign lo_idx = PTR_BITS'((w_eff - COUNT_BITS'(1)) >> 1);
   assign hi_idx = PTR_BITS'(w_eff >> 1);
   assign median_sum = RESULT_BITS'(cells[lo_idx].val) + RESULT_BITS'(cells[hi_idx].val);

   // ---------------- checks ----------------
   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == 32'(fill_count_ff))
      else $error("cell occupancy disagrees with fill count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS |=> fill_count_ff == $past(fill_count_ff) + COUNT_BITS'(1))
      else $error("insert did not grow the window by one");

   a_result_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> fill_count_ff == w_eff)
      else $error("result produced with the window not full");

   a_delete_only_overfull: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEL |-> fill_count_ff >= w_eff && fill_count_ff != '0)
      else $error("removal from a window that is not full");

endmodule

/* tb/sliding_window_median_test.sv */
// sliding_window_median_test: self-checking bench for the sliding window median block.
// Drives random and directed sample requests, predicts each doubled median, checks responses.
// Depends on swm_pkg, swm_if (req/rsp/csr channels) and sliding_window_median.
module sliding_window_median_test import swm_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // settle time before a csr write and at the end: after a window shrink from 64 down
   // to 1 the next request drops each surplus sample before it inserts
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();
   swm_csr_if csr_bus ();

   sliding_window_median dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source),
      .csr   (csr_bus.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: samples in arrival order (oldest at the front) and the
   // window_size register as last written.
   // ---------------------------------------------------------------------------
   sample_type                    window_history[$];
   logic [WSIZE_BITS-1:0]         window_size_reg = WSIZE_RESET;
   logic signed [RESULT_BITS-1:0] median_expected[$];

   int unsigned error_count   = 0;
   bit          idle_on       = 1'b1;  // random gaps on both sides when set
   int unsigned rsp_hold_left = 0;     // long response stall, counted down below

   // Update the window for one accepted request; queue the doubled median when
   // the window holds exactly the effective size.
   task automatic apply_sample(input sample_type s, input logic restart);
      int unsigned span;
      int unsigned pos;
      int unsigned lo_idx;
      int unsigned hi_idx;
      sample_type  ordered[$];
      logic signed [RESULT_BITS-1:0] lo_val;
      logic signed [RESULT_BITS-1:0] hi_val;
      logic signed [RESULT_BITS-1:0] sum_val;
      // size 0 behaves as 1, anything above the cell count as the cell count
      if (window_size_reg == 0)
         span = 1;
      else if (window_size_reg > WINDOW_MAX)
         span = WINDOW_MAX;
      else
         span = window_size_reg;
      if (restart)
         window_history.delete();
      // keep only the newest span-1 samples; also covers a shrunk window
      while (window_history.size() > span - 1)
         void'(window_history.pop_front());
      window_history.insert(window_history.size(), s);
      if (window_history.size() != span)
         return;
      foreach (window_history[i]) begin
         pos = 0;
         while (pos < ordered.size() && ordered[pos] <= window_history[i])
            pos++;
         ordered.insert(pos, window_history[i]);
      end
      if (span[0]) begin
         lo_idx = (span - 1) / 2;
         hi_idx = lo_idx;
      end else begin
         lo_idx = span / 2 - 1;
         hi_idx = span / 2;
      end
      lo_val  = ordered[lo_idx];
      hi_val  = ordered[hi_idx];
      sum_val = lo_val + hi_val;
      median_expected.insert(median_expected.size(), sum_val);
   endtask

   // ---------------------------------------------------------------------------
   // Request side. Inputs change on the falling edge; acceptance is seen at the
   // rising edge. valid stays up between back-to-back requests.
   // ---------------------------------------------------------------------------
   task automatic send_request(input sample_type s, input logic restart);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= s;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
      apply_sample(s, restart);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // all expected responses in, then let a pending shrink/drop finish
   task automatic wait_idle();
      while (median_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(input logic [WSIZE_BITS-1:0] size);
      end_burst();
      wait_idle();
      @(negedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.window_size <= size;
      do @(posedge clock); while (!csr_bus.ready);
      window_size_reg = size;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // mix of full-range values, a narrow band (lots of ties) and the rails
   function automatic sample_type rand_sample();
      case ($urandom_range(0, 3))
         0: return sample_type'($urandom_range(0, 8) - 4);
         1: begin
            case ($urandom_range(0, 3))
               0: return sample_type'(16'h8000);
               1: return sample_type'(16'h7fff);
               2: return sample_type'(16'h8001);
               default: return sample_type'(16'h7ffe);
            endcase
         end
         default: return sample_type'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: per-response random stall, plus the long hold-off.
   // ---------------------------------------------------------------------------
   initial begin : rsp_drain
      int unsigned stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            stall = idle_on ? $urandom_range(0, 15) : 0;
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare every accepted response with the oldest prediction
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (median_expected.size() == 0) begin
            $display("%0t: median_doubled expected none actual %0d",
                     $time, rsp_bus.median_doubled);
            error_count++;
         end else begin
            if (rsp_bus.median_doubled !== median_expected[0]) begin
               $display("%0t: median_doubled expected %0d actual %0d",
                        $time, median_expected[0], rsp_bus.median_doubled);
               error_count++;
            end
            void'(median_expected.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // reset window of 3: rails, ties, not-yet-full, restart
   task automatic test_reset_window();
      send_request(sample_type'(16'h8000), 1'b0);
      send_request(sample_type'(16'h7fff), 1'b0);   // still filling, no result
      send_request(sample_type'(-1), 1'b0);
      send_request(sample_type'(16'h7fff), 1'b0);
      send_request(sample_type'(16'h7fff), 1'b0);
      send_request(sample_type'(5), 1'b1);          // restart: window empties
      send_request(sample_type'(7), 1'b0);
      send_request(sample_type'(6), 1'b0);
      send_request(sample_type'(6), 1'b1);          // restart on a full window
   endtask

   // size 0 acts as 1: every request answers with twice its sample
   task automatic test_window_zero();
      set_window('0);
      send_request(sample_type'(16'h8000), 1'b0);
      send_request(sample_type'(16'h7fff), 1'b0);
      send_request(sample_type'(0), 1'b1);
   endtask

   // even window: sum of the two middle values, both rails
   task automatic test_even_window();
      set_window(WSIZE_BITS'(2));
      send_request(sample_type'(16'h8000), 1'b1);
      send_request(sample_type'(16'h8000), 1'b0);
      send_request(sample_type'(16'h7fff), 1'b0);
      send_request(sample_type'(16'h7fff), 1'b0);
      send_request(sample_type'(16'h8000), 1'b0);
   endtask

   // random phases over many sizes; 127 saturates to 64, the size 3 right after
   // it shrinks a full window; every other phase runs without idling
   task automatic test_window_sweep();
      logic [WSIZE_BITS-1:0] sizes[12] = '{7'd127, 7'd3, 7'd64, 7'd2, 7'd65, 7'd1,
                                           7'd16, 7'd7, 7'd40, 7'd4, 7'd31, 7'd6};
      int unsigned span;
      foreach (sizes[p]) begin
         set_window(sizes[p]);
         idle_on = p[0] ? 1'b0 : 1'b1;
         span = (sizes[p] > WINDOW_MAX) ? WINDOW_MAX : sizes[p];
         repeat (2 * span + 40)
            send_request(rand_sample(), $urandom_range(0, 49) == 0);
      end
      idle_on = 1'b1;
   endtask

   // long response stall while requests keep coming: the block must back up
   task automatic test_rsp_backpressure();
      set_window(WSIZE_BITS'(5));
      idle_on = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      repeat (60)
         send_request(rand_sample(), 1'b0);
      idle_on = 1'b1;
      repeat (20)
         send_request(rand_sample(), $urandom_range(0, 9) == 0);
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.sample      = '0;
      req_bus.restart     = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.window_size = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_window_zero();
      test_even_window();
      test_window_sweep();
      test_rsp_backpressure();

      end_burst();
      wait_idle();
      if (error_count == 0)
         $display("sliding_window_median: match");
      else
         $display("sliding_window_median: mismatch");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10ms;
      $display("sliding_window_median: mismatch");
      $finish;
   end

endmodule
